// ===== rtl/ltint_pkg.sv =====
// shared types, widths and register codes for the line translation interval block
// no dependencies; every other file of the block imports this package
package ltint_pkg;

  // fixed point formats
  localparam int NORMAL_FRAC_BITS = 15;
  localparam int NORM_W  = 16;
  localparam int COORD_W = 32;
  localparam int TOL_W   = 31;
  localparam int TAG_W   = 16;

  // arithmetic widths: products, tolerance in product format, accumulated bounds
  localparam int PROD_W = NORM_W + 1 + COORD_W;
  localparam int EPS_W  = TOL_W + NORMAL_FRAC_BITS;
  localparam int ACC_W  = ((PROD_W > EPS_W + 1) ? PROD_W : EPS_W + 1) + 3;
  localparam int MAG_W  = ACC_W - 1;
  localparam int DIV_W  = NORM_W;

  // pipeline shape
  localparam int FRONT_STAGES = 6;
  localparam int DIV_CELLS    = MAG_W;
  localparam int BACK_STAGES  = 1;
  localparam int OUT_DEPTH    = 2;
  localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);
  localparam int PIPE_CAP     = FRONT_STAGES + DIV_CELLS + BACK_STAGES + OUT_DEPTH;
  localparam int PIPE_CNT_W   = $clog2(PIPE_CAP + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE = 3'd0,
    REG_X_LIMIT   = 3'd1,
    REG_BOX_Y_MIN = 3'd2,
    REG_BOX_Y_MAX = 3'd3,
    REG_BOX_Z_MIN = 3'd4,
    REG_BOX_Z_MAX = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        [TOL_W-1:0]   tolerance;
    logic        [TOL_W-1:0]   x_limit;
    logic signed [COORD_W-1:0] box_y_min;
    logic signed [COORD_W-1:0] box_y_max;
    logic signed [COORD_W-1:0] box_z_min;
    logic signed [COORD_W-1:0] box_z_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tolerance: 31'd6554,
    x_limit:   31'd655360,
    box_y_min: 32'sd0,
    box_y_max: 32'sd65536,
    box_z_min: 32'sd0,
    box_z_max: 32'sd65536
  };

  typedef struct packed {
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;
    logic signed [NORM_W-1:0]  normal_z;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic        [TAG_W-1:0]   line_tag;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [TOL_W-1:0] interval_low;
    logic [TOL_W-1:0] interval_high;
    logic [TAG_W-1:0] tag_out;
  } out_word_t;

  // one restoring division in flight: partial remainder, dividend bits left, quotient so far
  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [MAG_W-1:0] dvd;
    logic [MAG_W-1:0] quo;
  } div_lane_t;

  // word handed from cell to cell: upper bound lane, lower bound lane and side info
  typedef struct packed {
    div_lane_t        lane_u;
    div_lane_t        lane_l;
    logic [DIV_W-1:0] divisor;
    logic             nx_zero;
    logic             cmax_neg;
    logic             cmin_pos;
    logic [TAG_W-1:0] tag;
  } div_word_t;

endpackage

// ===== rtl/ltint_in_if.sv =====
// input channel carrying one line constraint word
// depends on ltint_pkg
interface ltint_in_if;
  import ltint_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ltint_out_if.sv =====
// output channel carrying one interval result word
// depends on ltint_pkg
interface ltint_out_if;
  import ltint_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ltint_cfg_if.sv =====
// configuration write channel: register index and write data
// depends on ltint_pkg
interface ltint_cfg_if;
  import ltint_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/line_translation_interval.sv =====
// top level of the line translation interval block
// depends on ltint_pkg, the channel interfaces, ltint_regs, ltint_front, ltint_div_cell, ltint_back

// One line constraint word is taken per clock cycle and one result word leaves per
// cycle in steady state while the output buffer is not full. A word spends 6 front
// stages, 51 divider cells (one quotient bit per cell, both interval ends in
// parallel), 1 clamp stage and one write into the output buffer before its result is
// offered. The divider chain is the longest part: it is one cell per bit of the widest
// constant-term magnitude. A two-word output buffer decouples the sides; when the
// buffer is full the whole pipeline holds and lines.ready stays low until the cycle
// after the sink takes a word. Configuration is always ready and must only be written
// while no word is in flight.
module line_translation_interval (
  input logic            clk,
  input logic            rst,
  ltint_in_if.sink       lines,
  ltint_out_if.source    intervals,
  ltint_cfg_if.sink      cfg
);
  import ltint_pkg::*;

  cfg_t      cfg_regs;
  logic      en;
  div_word_t dw [DIV_CELLS+1];
  logic      dv [DIV_CELLS+1];

  // configuration registers
  assign cfg.ready = 1'b1;

  ltint_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  // input side
  assign lines.ready = en;

  ltint_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (lines.valid),
    .in_word  (lines.data),
    .cfg      (cfg_regs),
    .out_vld  (dv[0]),
    .out_word (dw[0])
  );

  // divider chain
  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
    ltint_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vld_in   (dv[g]),
      .word_in  (dw[g]),
      .vld_out  (dv[g+1]),
      .word_out (dw[g+1])
    );
  end

  // clamp and output buffer
  ltint_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (dv[DIV_CELLS]),
    .in_word   (dw[DIV_CELLS]),
    .cfg       (cfg_regs),
    .en        (en),
    .out_valid (intervals.valid),
    .out_ready (intervals.ready),
    .out_word  (intervals.data)
  );
endmodule

// ===== rtl/ltint_regs.sv =====
// configuration register file: tolerance, x limit and the y-z box
// depends on ltint_pkg
module ltint_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_valid,
  input  logic [ltint_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ltint_pkg::CFG_DATA_W-1:0] wr_data,
  output ltint_pkg::cfg_t                 cfg
);
  import ltint_pkg::*;

  cfg_t cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= CFG_RESET;
    end else if (wr_valid) begin
      case (wr_index)
        REG_TOLERANCE: cfg_q.tolerance <= wr_data[TOL_W-1:0];
        REG_X_LIMIT:   cfg_q.x_limit   <= wr_data[TOL_W-1:0];
        REG_BOX_Y_MIN: cfg_q.box_y_min <= signed'(wr_data[COORD_W-1:0]);
        REG_BOX_Y_MAX: cfg_q.box_y_max <= signed'(wr_data[COORD_W-1:0]);
        REG_BOX_Z_MIN: cfg_q.box_z_min <= signed'(wr_data[COORD_W-1:0]);
        REG_BOX_Z_MAX: cfg_q.box_z_max <= signed'(wr_data[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_q;
endmodule

// ===== rtl/ltint_front.sv =====
// front pipeline: normal flip, products, box corner extremes, constant bounds, magnitudes
// depends on ltint_pkg; feeds the first divider cell
module ltint_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  ltint_pkg::in_word_t  in_word,
  input  ltint_pkg::cfg_t      cfg,
  output logic                 out_vld,
  output ltint_pkg::div_word_t out_word
);
  import ltint_pkg::*;

  logic [FRONT_STAGES-1:0] vld;

  // stage 1: flip the normal so that n_x is not negative
  logic                      flip;
  logic signed [NORM_W:0]    nx_ext, ny_ext, nz_ext;
  logic signed [NORM_W:0]    nx1, ny1, nz1;
  logic signed [COORD_W-1:0] px1, py1, pz1;
  logic        [TAG_W-1:0]   tag1;

  assign flip   = in_word.normal_x[NORM_W-1];
  assign nx_ext = (NORM_W+1)'(in_word.normal_x);
  assign ny_ext = (NORM_W+1)'(in_word.normal_y);
  assign nz_ext = (NORM_W+1)'(in_word.normal_z);

  always_ff @(posedge clk) begin
    if (en) begin
      nx1  <= flip ? -nx_ext : nx_ext;
      ny1  <= flip ? -ny_ext : ny_ext;
      nz1  <= flip ? -nz_ext : nz_ext;
      px1  <= in_word.point_x;
      py1  <= in_word.point_y;
      pz1  <= in_word.point_z;
      tag1 <= in_word.line_tag;
    end
  end

  // stage 2: all products, one multiplier each
  logic signed [PROD_W-1:0] pxx, pyy, pzz, pymn, pymx, pzmn, pzmx;
  logic        [DIV_W-1:0]  nx2;
  logic        [TAG_W-1:0]  tag2;

  always_ff @(posedge clk) begin
    if (en) begin
      pxx  <= PROD_W'(nx1) * PROD_W'(px1);
      pyy  <= PROD_W'(ny1) * PROD_W'(py1);
      pzz  <= PROD_W'(nz1) * PROD_W'(pz1);
      pymn <= PROD_W'(ny1) * PROD_W'(cfg.box_y_min);
      pymx <= PROD_W'(ny1) * PROD_W'(cfg.box_y_max);
      pzmn <= PROD_W'(nz1) * PROD_W'(cfg.box_z_min);
      pzmx <= PROD_W'(nz1) * PROD_W'(cfg.box_z_max);
      nx2  <= nx1[DIV_W-1:0];
      tag2 <= tag1;
    end
  end

  // stage 3: plane constant and corner extremes of the y and z terms
  logic signed [ACC_W-1:0]  c3;
  logic signed [PROD_W-1:0] tylo3, tyhi3, tzlo3, tzhi3;
  logic        [DIV_W-1:0]  nx3;
  logic        [TAG_W-1:0]  tag3;

  always_ff @(posedge clk) begin
    if (en) begin
      c3    <= ACC_W'(pxx) + ACC_W'(pyy) + ACC_W'(pzz);
      tylo3 <= (pymn < pymx) ? pymn : pymx;
      tyhi3 <= (pymn > pymx) ? pymn : pymx;
      tzlo3 <= (pzmn < pzmx) ? pzmn : pzmx;
      tzhi3 <= (pzmn > pzmx) ? pzmn : pzmx;
      nx3   <= nx2;
      tag3  <= tag2;
    end
  end

  // stage 4: tolerance terms and corner sums
  logic signed [ACC_W-1:0] eps;
  logic signed [ACC_W-1:0] cpe4, cme4, slo4, shi4;
  logic        [DIV_W-1:0] nx4;
  logic        [TAG_W-1:0] tag4;

  assign eps = signed'(ACC_W'({cfg.tolerance, {NORMAL_FRAC_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    if (en) begin
      cpe4 <= c3 + eps;
      cme4 <= c3 - eps;
      slo4 <= ACC_W'(tylo3) + ACC_W'(tzlo3);
      shi4 <= ACC_W'(tyhi3) + ACC_W'(tzhi3);
      nx4  <= nx3;
      tag4 <= tag3;
    end
  end

  // stage 5: upper and lower bounds of the constant term
  logic signed [ACC_W-1:0] cmax5, cmin5;
  logic        [DIV_W-1:0] nx5;
  logic        [TAG_W-1:0] tag5;

  always_ff @(posedge clk) begin
    if (en) begin
      cmax5 <= cpe4 - slo4;
      cmin5 <= cme4 - shi4;
      nx5   <= nx4;
      tag5  <= tag4;
    end
  end

  // stage 6: signs and magnitudes for the divider chain
  logic signed [ACC_W-1:0] cmax_abs, cmin_abs;
  div_word_t               w6;

  assign cmax_abs = cmax5[ACC_W-1] ? -cmax5 : cmax5;
  assign cmin_abs = cmin5[ACC_W-1] ? -cmin5 : cmin5;

  always_ff @(posedge clk) begin
    if (en) begin
      w6.lane_u.rem <= '0;
      w6.lane_u.dvd <= cmax_abs[MAG_W-1:0];
      w6.lane_u.quo <= '0;
      w6.lane_l.rem <= '0;
      w6.lane_l.dvd <= cmin_abs[MAG_W-1:0];
      w6.lane_l.quo <= '0;
      w6.divisor    <= nx5;
      w6.nx_zero    <= (nx5 == '0);
      w6.cmax_neg   <= cmax5[ACC_W-1];
      w6.cmin_pos   <= !cmin5[ACC_W-1] && (cmin5 != '0);
      w6.tag        <= tag5;
    end
  end

  // valid bits of the six stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT_STAGES-2:0], in_vld};
    end
  end

  assign out_vld  = vld[FRONT_STAGES-1];
  assign out_word = w6;
endmodule

// ===== rtl/ltint_div_cell.sv =====
// one divider cell: a restoring step for both bounds, one quotient bit each
// depends on ltint_pkg; cells are chained in the top level
module ltint_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  ltint_pkg::div_word_t word_in,
  output logic                 vld_out,
  output ltint_pkg::div_word_t word_out
);
  import ltint_pkg::*;

  function automatic div_lane_t div_step(input div_lane_t ln, input logic [DIV_W-1:0] d);
    logic [DIV_W:0] sh;
    logic [DIV_W:0] diff;
    logic           ge;
    div_lane_t      r;
    sh    = {ln.rem, ln.dvd[MAG_W-1]};
    ge    = (sh >= {1'b0, d});
    diff  = sh - {1'b0, d};
    r.rem = ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
    r.dvd = {ln.dvd[MAG_W-2:0], 1'b0};
    r.quo = {ln.quo[MAG_W-2:0], ge};
    return r;
  endfunction

  div_word_t word_next;
  div_word_t word_q;
  logic      vld_q;

  // side info passes through, each lane gains its next quotient bit
  always_comb begin
    word_next        = word_in;
    word_next.lane_u = div_step(word_in.lane_u, word_in.divisor);
    word_next.lane_l = div_step(word_in.lane_l, word_in.divisor);
  end

  // payload moves on to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      word_q <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= vld_in;
    end
  end

  assign vld_out  = vld_q;
  assign word_out = word_q;
endmodule

// ===== rtl/ltint_back.sv =====
// back end: rounding, clamping to [0, x_limit], emptiness test and the output buffer
// depends on ltint_pkg; takes the word leaving the last divider cell
module ltint_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  ltint_pkg::div_word_t in_word,
  input  ltint_pkg::cfg_t      cfg,
  output logic                 en,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ltint_pkg::out_word_t out_word
);
  import ltint_pkg::*;

  // clamp the floor quotient, round the lower quotient up
  logic             over;
  logic             rnz;
  logic             b1_vld;
  logic             ok1;
  logic [TOL_W-1:0] hi1;
  logic [MAG_W:0]   lo1;
  logic [TAG_W-1:0] tag1;

  assign over = in_word.lane_u.quo > MAG_W'(cfg.x_limit);
  assign rnz  = (in_word.lane_l.rem != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      tag1 <= in_word.tag;
      if (in_word.nx_zero) begin
        ok1 <= !in_word.cmax_neg && !in_word.cmin_pos;
        hi1 <= cfg.x_limit;
        lo1 <= '0;
      end else begin
        ok1 <= !in_word.cmax_neg;
        hi1 <= over ? cfg.x_limit : in_word.lane_u.quo[TOL_W-1:0];
        lo1 <= in_word.cmin_pos ? ((MAG_W+1)'(in_word.lane_l.quo) + (MAG_W+1)'(rnz)) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld <= 1'b0;
    end else if (en) begin
      b1_vld <= in_vld;
    end
  end

  // emptiness test and result word
  logic      found;
  out_word_t res;

  assign found             = ok1 && (lo1 <= (MAG_W+1)'(hi1));
  assign res.found         = found;
  assign res.interval_low  = found ? lo1[TOL_W-1:0] : '0;
  assign res.interval_high = found ? hi1 : '0;
  assign res.tag_out       = tag1;

  // output buffer: the pipeline keeps moving while a word waits here and the buffer is not full
  out_word_t            obuf [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OUT_CNT_W-1:0] count;
  logic                 push, pop;

  assign push = en && b1_vld;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  assign en        = (count != OUT_CNT_W'(OUT_DEPTH));
  assign out_valid = (count != '0);
  assign out_word  = obuf[rd_ptr];
endmodule

// ===== rtl/ltint_checker.sv =====
// port-level checks for the line translation interval block, bound to the top level
// depends on ltint_pkg and line_translation_interval
module ltint_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input ltint_pkg::out_word_t out_word
);
  import ltint_pkg::*;

  logic                  in_acc, out_acc;
  logic [PIPE_CNT_W-1:0] outstanding;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + PIPE_CNT_W'(in_acc) - PIPE_CNT_W'(out_acc);
    end
  end

  a_no_spurious_word: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> outstanding != '0)
    else $error("result word delivered with nothing in flight");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> outstanding < PIPE_CNT_W'(PIPE_CAP))
    else $error("input word accepted beyond pipeline capacity");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_ordered_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.found |-> out_word.interval_low <= out_word.interval_high)
    else $error("found interval has low end above high end");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.found |->
      out_word.interval_low == '0 && out_word.interval_high == '0)
    else $error("empty interval carries nonzero ends");
endmodule

bind line_translation_interval ltint_checker u_ltint_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (lines.valid),
  .in_ready  (lines.ready),
  .out_valid (intervals.valid),
  .out_ready (intervals.ready),
  .out_word  (intervals.data)
);
